FILE: sv/dmwc_pkg.sv
// Shared types, codes and default sizes for the direct-mapped write-back cache controller.
// Used by dmwc_ctrl, dmwc_dpath and the top level; depends on nothing else.
package dmwc_pkg;

	localparam int CACHE_SLOTS_DEF     = 1024;
	localparam int BLOCK_ADDR_BITS_DEF = 32;

	localparam int MODE_W     = 2;
	localparam int BLOCK_W    = 32;
	localparam int ACTION_W   = 3;
	localparam int SLOT_OUT_W = 10;

	localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DONE  = 2'd2;

	localparam logic [ACTION_W-1:0] ACT_HIT    = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_FETCH  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_POSTED = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_RETRY  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_DONE   = 3'd4;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_PROD,
		ST_READ,
		ST_EVAL
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_wr;
		logic load;
		logic mul;
		logic prod;
		logic read;
		logic eval;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic clear_last;
	} sts_t;

endpackage

FILE: sv/direct_mapped_writeback_cache_ctrl_top.sv
// Top level of the direct-mapped write-back cache tag/dirty controller.
// Depends on dmwc_pkg, dmwc_ctrl and dmwc_dpath.
//
// Input channel: drive mode and block_number and raise start; the word is taken at a
//   rising edge where start is high and busy is low. Modes: read block, write block,
//   remote write completed; mode 3 words give no result.
// Result channel: done strobes high for exactly one cycle with action, slot,
//   remote_request_valid and remote_block. The receiver cannot stall: sample the
//   result on the cycle done is high.
// Sequence: the word is taken into a reciprocal multiply that maps block_number to its
//   slot (two registered multiplier stages), then the slot store is read (registered
//   read port), the hit/dirty decision writes the row back on a fetch, a posted write
//   or a completion, and the result is registered. done rises as the sequencer returns
//   to idle and busy drops in that same cycle, so the next word can be taken on the
//   edge that ends the done strobe. The block takes one word at a time.
//   Slot state lives in one memory row per slot: valid, dirty and tag.
// Reset: arst_n low clears the sequencer; after release a clearing pass writes all
//   CACHE_SLOTS rows to invalid/clean, one row per cycle, with busy held high until
//   the pass ends.
module direct_mapped_writeback_cache_ctrl_top #(
	parameter int CACHE_SLOTS     = dmwc_pkg::CACHE_SLOTS_DEF,
	parameter int BLOCK_ADDR_BITS = dmwc_pkg::BLOCK_ADDR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [dmwc_pkg::MODE_W-1:0]     mode,
	input  logic [dmwc_pkg::BLOCK_W-1:0]    block_number,
	output logic                            done,
	output logic [dmwc_pkg::ACTION_W-1:0]   action,
	output logic [dmwc_pkg::SLOT_OUT_W-1:0] slot,
	output logic                            remote_request_valid,
	output logic [dmwc_pkg::BLOCK_W-1:0]    remote_block
);
	import dmwc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequence each word through map, read and decide.
	dmwc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Hold the word, map it to a slot, update the row and register the result.
	dmwc_dpath #(
		.CACHE_SLOTS     (CACHE_SLOTS),
		.BLOCK_ADDR_BITS (BLOCK_ADDR_BITS)
	) u_dpath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.sts                  (sts),
		.mode                 (mode),
		.block_number         (block_number),
		.done                 (done),
		.action               (action),
		.slot                 (slot),
		.remote_request_valid (remote_request_valid),
		.remote_block         (remote_block)
	);

endmodule

FILE: sv/dmwc_ctrl.sv
// Sequencer for the cache controller: clearing pass after reset, then one word at a time.
// Depends on dmwc_pkg for the state type and the command/status structs.
module dmwc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  dmwc_pkg::sts_t sts,
	output dmwc_pkg::cmd_t cmd,
	output logic          busy
);
	import dmwc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_PROD;
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_READ;
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

FILE: sv/dmwc_dpath.sv
// Datapath: slot mapping by reciprocal multiply, slot store and hit/dirty decision.
// Depends on dmwc_pkg; driven by dmwc_ctrl through cmd_t, reports through sts_t.
module dmwc_dpath #(
	parameter int CACHE_SLOTS     = dmwc_pkg::CACHE_SLOTS_DEF,
	parameter int BLOCK_ADDR_BITS = dmwc_pkg::BLOCK_ADDR_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dmwc_pkg::cmd_t                    cmd,
	output dmwc_pkg::sts_t                    sts,
	input  logic [dmwc_pkg::MODE_W-1:0]       mode,
	input  logic [dmwc_pkg::BLOCK_W-1:0]      block_number,
	output logic                              done,
	output logic [dmwc_pkg::ACTION_W-1:0]     action,
	output logic [dmwc_pkg::SLOT_OUT_W-1:0]   slot,
	output logic                              remote_request_valid,
	output logic [dmwc_pkg::BLOCK_W-1:0]      remote_block
);
	import dmwc_pkg::*;

	localparam int SLOT_W    = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
	localparam int TAG_W     = (BLOCK_ADDR_BITS < BLOCK_W) ? BLOCK_ADDR_BITS : BLOCK_W;
	localparam int ROW_W     = TAG_W + 2;
	localparam int RECIP_W   = BLOCK_W + 1;
	localparam int PROD_W    = BLOCK_W + RECIP_W;
	localparam int SHIFT     = BLOCK_W + SLOT_W;
	localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(CACHE_SLOTS);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
	localparam logic [BLOCK_W-1:0] DIVISOR = BLOCK_W'(CACHE_SLOTS);
	localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(CACHE_SLOTS - 1);

	// Row layout: valid, dirty, tag.
	logic [ROW_W-1:0] mem_q [CACHE_SLOTS];

	logic [SLOT_W-1:0]  clr_cnt_q;
	logic [MODE_W-1:0]  mode_q;
	logic [BLOCK_W-1:0] blk_q;
	logic [PROD_W-1:0]  prod_s1;
	logic [BLOCK_W-1:0] qd_s2;
	logic [SLOT_W-1:0]  slot_q;
	logic [ROW_W-1:0]   rdata_q;

	logic [BLOCK_W-1:0] q_est;
	logic [BLOCK_W-1:0] rem;
	logic [BLOCK_W-1:0] rem_fix;
	logic [SLOT_W-1:0]  slot_c;
	logic [TAG_W-1:0]   tag_c;
	logic [BLOCK_W-1:0] slot_ext;

	logic               row_v;
	logic               row_d;
	logic [TAG_W-1:0]   row_t;
	logic               wr_en;
	logic [ROW_W-1:0]   wdata;
	logic [ACTION_W-1:0] act_c;
	logic               req_c;
	logic               emit_c;

	logic               done_q;
	logic [ACTION_W-1:0] action_q;
	logic [SLOT_OUT_W-1:0] slot_out_q;
	logic               req_q;
	logic [BLOCK_W-1:0] rblk_q;

	// Clearing pass after reset: a counter walks through every row until the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
		end
	end

	assign sts.clear_last = (clr_cnt_q == LAST_SLOT);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			blk_q  <= block_number;
		end
		if (cmd.mul) begin
			prod_s1 <= PROD_W'(blk_q) * PROD_W'(RECIP);
		end
		if (cmd.prod) begin
			qd_s2 <= q_est * DIVISOR;
		end
		if (cmd.read) begin
			slot_q <= slot_c;
		end
	end

	// Quotient estimate is exact or one short; one correction step fixes the remainder.
	assign q_est   = BLOCK_W'(prod_s1 >> SHIFT);
	assign rem     = blk_q - qd_s2;
	assign rem_fix = (rem >= DIVISOR) ? (rem - DIVISOR) : rem;
	assign slot_c  = rem_fix[SLOT_W-1:0];
	assign tag_c   = blk_q[TAG_W-1:0];

	// Slot store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.clear_wr) begin
			mem_q[clr_cnt_q] <= '0;
		end else if (wr_en) begin
			mem_q[slot_q] <= wdata;
		end
		if (cmd.read) begin
			rdata_q <= mem_q[slot_c];
		end
	end

	assign row_v = rdata_q[ROW_W-1];
	assign row_d = rdata_q[ROW_W-2];
	assign row_t = rdata_q[TAG_W-1:0];

	always_comb begin
		wr_en  = 1'b0;
		wdata  = {row_v, row_d, row_t};
		act_c  = ACT_HIT;
		req_c  = 1'b0;
		emit_c = 1'b0;
		if (cmd.eval) begin
			unique case (mode_q)
				MODE_READ: begin
					emit_c = 1'b1;
					if (row_v && (row_t == tag_c)) begin
						act_c = ACT_HIT;
					end else if (row_v && row_d) begin
						act_c = ACT_RETRY;
					end else begin
						act_c = ACT_FETCH;
						req_c = 1'b1;
						wr_en = 1'b1;
						wdata = {1'b1, row_d, tag_c};
					end
				end
				MODE_WRITE: begin
					emit_c = 1'b1;
					if (row_v && row_d) begin
						act_c = ACT_RETRY;
					end else begin
						act_c = ACT_POSTED;
						req_c = 1'b1;
						wr_en = 1'b1;
						wdata = {1'b1, 1'b1, tag_c};
					end
				end
				MODE_DONE: begin
					emit_c = 1'b1;
					act_c  = ACT_DONE;
					wr_en  = 1'b1;
					wdata  = {row_v, 1'b0, row_t};
				end
				default: begin
					emit_c = 1'b0;
				end
			endcase
		end
	end

	assign slot_ext = BLOCK_W'(slot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_c) begin
			action_q   <= act_c;
			slot_out_q <= slot_ext[SLOT_OUT_W-1:0];
			req_q      <= req_c;
			rblk_q     <= req_c ? blk_q : '0;
		end
	end

	assign done                 = done_q;
	assign action               = action_q;
	assign slot                 = slot_out_q;
	assign remote_request_valid = req_q;
	assign remote_block         = rblk_q;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for direct_mapped_writeback_cache_ctrl_top.
// A directed pass, random traffic over a few crowded slots and a drained burst are each
// checked against a predictor of the valid/dirty/tag store. Depends on dmwc_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
	import dmwc_pkg::*;

	localparam int SLOTS          = CACHE_SLOTS_DEF;
	// The clearing pass after reset holds busy while it writes all SLOTS rows; the limit is set several times above SLOTS.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 20;
	localparam int POSTED_KEEP    = 16;
	localparam int UPPER_W        = BLOCK_W - SLOT_OUT_W;

	// This mode code has no meaning; the block drops it without a result.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		logic [ACTION_W-1:0]   action;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  req;
		logic [BLOCK_W-1:0]    rblock;
	} cache_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [MODE_W-1:0]     mode;
	logic [BLOCK_W-1:0]    block_number;
	logic                  done;
	logic [ACTION_W-1:0]   action;
	logic [SLOT_OUT_W-1:0] slot;
	logic                  remote_request_valid;
	logic [BLOCK_W-1:0]    remote_block;

	// Predicted slot store: one valid bit, dirty bit and tag per slot.
	bit                 line_valid [SLOTS];
	bit                 line_dirty [SLOTS];
	logic [BLOCK_W-1:0] line_tag   [SLOTS];

	cache_result_t      expected_results [$];
	logic [BLOCK_W-1:0] posted_blocks [$];
	int                 error_count = 0;
	int                 stall_cycles = 0;

	direct_mapped_writeback_cache_ctrl_top u_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.start                (start),
		.busy                 (busy),
		.mode                 (mode),
		.block_number         (block_number),
		.done                 (done),
		.action               (action),
		.slot                 (slot),
		.remote_request_valid (remote_request_valid),
		.remote_block         (remote_block)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		error_count++;
	endtask

	// Work out what one word does to the slot store and what it returns.
	// Return 0 for a word that gives no result.
	function automatic bit predict_cache_word(input logic [MODE_W-1:0] m,
			input logic [BLOCK_W-1:0] b, output cache_result_t r);
		int unsigned idx;
		idx      = b % SLOTS;
		r.action = ACT_HIT;
		r.slot   = idx[SLOT_OUT_W-1:0];
		r.req    = 1'b0;
		r.rblock = '0;
		case (m)
			MODE_READ: begin
				if (!line_valid[idx] || (line_tag[idx] != b && !line_dirty[idx])) begin
					// Miss on an invalid or clean slot: fetch and install the tag.
					line_valid[idx] = 1'b1;
					line_tag[idx]   = b;
					r.action        = ACT_FETCH;
					r.req           = 1'b1;
					r.rblock        = b;
				end else if (line_tag[idx] != b) begin
					r.action = ACT_RETRY;
				end
			end
			MODE_WRITE: begin
				if (line_valid[idx] && line_dirty[idx]) begin
					r.action = ACT_RETRY;
				end else begin
					line_valid[idx] = 1'b1;
					line_dirty[idx] = 1'b1;
					line_tag[idx]   = b;
					r.action        = ACT_POSTED;
					r.req           = 1'b1;
					r.rblock        = b;
				end
			end
			MODE_DONE: begin
				// Clear dirty whatever the tag or valid bit says.
				line_dirty[idx] = 1'b0;
				r.action        = ACT_DONE;
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// Present one word at the falling edge and hold it until the block takes it.
	task automatic send_word(input logic [MODE_W-1:0] m, input logic [BLOCK_W-1:0] b);
		cache_result_t r;
		@(negedge clk);
		start        = 1'b1;
		mode         = m;
		block_number = b;
		do @(posedge clk); while (busy !== 1'b0);
		if (predict_cache_word(m, b, r)) begin
			expected_results.push_back(r);
			if (r.action == ACT_POSTED) begin
				posted_blocks.push_back(b);
				if (posted_blocks.size() > POSTED_KEEP)
					void'(posted_blocks.pop_front());
			end
		end
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Often back-to-back, as often a short gap, now and then a long pause.
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Crowd most traffic onto a few slots and a few tags so that hits, conflicts
	// and dirty retries are common; the rest is fully random.
	function automatic logic [BLOCK_W-1:0] random_block();
		logic [SLOT_OUT_W-1:0] s;
		logic [UPPER_W-1:0]    u;
		if ($urandom_range(0, 9) < 7) begin
			case ($urandom_range(0, 7))
				0: s = 10'd0;
				1: s = 10'd1;
				2: s = 10'd2;
				3: s = 10'd511;
				4: s = 10'd512;
				5: s = 10'd1021;
				6: s = 10'd1022;
				default: s = 10'd1023;
			endcase
		end else begin
			s = SLOT_OUT_W'($urandom_range(0, SLOTS - 1));
		end
		if ($urandom_range(0, 9) < 6) begin
			case ($urandom_range(0, 3))
				0: u = '0;
				1: u = '1;
				2: u = 22'h155555;
				default: u = 22'h2AAAAA;
			endcase
		end else begin
			u = UPPER_W'($urandom);
		end
		return {u, s};
	endfunction

	// Every case of the store: fetch on invalid, hit, hit while dirty, retry on
	// a dirty conflict, retry on a dirty rewrite, refill of a clean slot,
	// completion on a foreign tag and on an invalid slot, and the dropped mode.
	task automatic test_directed();
		send_word(MODE_READ,  32'h0000_0000);
		send_word(MODE_READ,  32'h0000_0000);
		send_word(MODE_READ,  32'hFFFF_FFFF);
		send_word(MODE_WRITE, 32'hFFFF_FFFF);
		send_word(MODE_READ,  32'hFFFF_FFFF);
		send_word(MODE_READ,  32'h0000_03FF);
		send_word(MODE_WRITE, 32'h0000_03FF);
		send_word(MODE_WRITE, 32'hFFFF_FFFF);
		idle_cycles(3);
		send_word(MODE_DONE,  32'hFFFF_FFFF);
		send_word(MODE_READ,  32'h0000_03FF);
		send_word(MODE_WRITE, 32'h0000_03FF);
		send_word(MODE_WRITE, 32'h0000_0400);
		send_word(MODE_DONE,  32'h1234_5400);
		send_word(MODE_WRITE, 32'h0000_0000);
		send_word(MODE_DONE,  32'h0000_0801);
		send_word(MODE_UNUSED, 32'h0000_0801);
		send_word(MODE_WRITE, 32'h0000_0801);
		send_word(MODE_READ,  32'h0000_0801);
		send_word(MODE_READ,  32'hAAAA_AAAA);
		send_word(MODE_READ,  32'h5555_5555);
		send_word(MODE_WRITE, 32'hAAAA_AAAA);
		send_word(MODE_UNUSED, 32'hFFFF_FFFF);
		send_word(MODE_READ,  32'h8000_0200);
		idle_cycles(random_gap());
	endtask

	// Random words; completions mostly follow posted writes. Dropped words do not count.
	task automatic test_random_traffic(input int count, input bit with_gaps);
		int                 sent;
		int                 pick;
		logic [MODE_W-1:0]  m;
		logic [BLOCK_W-1:0] b;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				m = MODE_READ;
			else if (pick < 72)
				m = MODE_WRITE;
			else if (pick < 96)
				m = MODE_DONE;
			else
				m = MODE_UNUSED;
			b = random_block();
			if (posted_blocks.size() != 0) begin
				if ((m == MODE_DONE && $urandom_range(0, 3) != 0) ||
						(m == MODE_READ && $urandom_range(0, 3) == 0))
					b = posted_blocks[$urandom_range(0, posted_blocks.size() - 1)];
			end
			send_word(m, b);
			if (m != MODE_UNUSED)
				sent++;
			if (with_gaps)
				idle_cycles(random_gap());
		end
	endtask

	// Send a back-to-back run, hold the sender until the block has answered everything, then hit it back to back again.
	task automatic test_drain_then_burst();
		test_random_traffic(40, 1'b0);
		wait_drained();
		test_random_traffic(40, 1'b0);
	endtask

	// Check each result against the oldest expected one.
	always @(posedge clk) begin : result_check
		cache_result_t e;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result action=%0d slot=%0d block=%h",
					action, slot, remote_block));
			end else begin
				e = expected_results.pop_front();
				if (action !== e.action)
					report_mismatch($sformatf("slot %0d: action %0d, want %0d",
						e.slot, action, e.action));
				if (slot !== e.slot)
					report_mismatch($sformatf("slot %0d, want %0d", slot, e.slot));
				if (remote_request_valid !== e.req)
					report_mismatch($sformatf("slot %0d: remote_request_valid %b, want %b",
						e.slot, remote_request_valid, e.req));
				if (remote_block !== e.rblock)
					report_mismatch($sformatf("slot %0d: remote_block %h, want %h",
						e.slot, remote_block, e.rblock));
			end
		end
	end

	// End the run if neither side moves for too long.
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		mode         = MODE_READ;
		block_number = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_traffic(250, 1'b1);
		test_drain_then_burst();
		test_random_traffic(200, 1'b1);

		// Drain, then give a trailing dropped word time to finish.
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
